// ----- rtl/sat_pkg.sv -----
// Shared types and constants for the sorted array table.
// Holds store geometry, the operation codes and the per-cell command struct.
package sat_pkg;

	localparam int DEPTH     = 64;
	localparam int KEY_WIDTH = 32;
	localparam int POS_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [POS_W-1:0]            pos_t;
	typedef logic [CNT_W-1:0]            cnt_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_SELECT = 2'd3
	} op_t;

	// Broadcast to every cell in the chain
	typedef struct packed {
		op_t  op;
		key_t key;
		logic shift_up;
		logic shift_down;
	} sat_cmd_t;

endpackage

// ----- rtl/sat_cell.sv -----
// One cell of the sorted chain: holds one key and its valid bit.
// Compares against the broadcast key and shifts with its neighbors. Uses sat_pkg.
module sat_cell
	import sat_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  sat_cmd_t cmd,
	input  key_t     left_key,
	input  logic     left_flag,
	input  logic     left_valid,
	input  key_t     right_key,
	input  logic     right_valid,
	output key_t     key_q,
	output logic     valid_q,
	output logic     flag,
	output logic     match
);

	key_t key_n;
	logic valid_n;

	// Flag the cells that stay below the target: at or below for insert, strictly below otherwise
	always_comb begin
		if (cmd.op == OP_INSERT) begin
			flag = valid_q && (key_q <= cmd.key);
		end else begin
			flag = valid_q && (key_q < cmd.key);
		end
		match = valid_q && (key_q == cmd.key);
	end

	// Take the new key at the insert point, shift up above it, or close the gap on remove
	always_comb begin
		key_n   = key_q;
		valid_n = valid_q;
		if (cmd.shift_up && !flag) begin
			key_n   = left_flag ? cmd.key : left_key;
			valid_n = left_flag | left_valid;
		end else if (cmd.shift_down && !flag) begin
			key_n   = right_key;
			valid_n = right_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_n;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_n;
	end

endmodule

// ----- rtl/sorted_array_table.sv -----
// Sorted array table: keeps up to DEPTH signed keys in ascending order.
// Request channel (req_valid/req_stall) carries one transaction per operation:
// insert, search, remove or select by rank. Response channel (rsp_valid/rsp_stall)
// returns exactly one transaction per request, in order, with hit, found_key,
// position, entry_count and refused.
// A request is registered in the request stage at acceptance and executed, once the
// response register is free, by a chain of DEPTH cells that all compare against the key
// and shift together. The response register loads at the end of the execute cycle and
// raises rsp_valid; the response is taken at an edge where rsp_stall is low.
// Throughput: one transaction per cycle while no response stall holds it; the single
// execute stage and its one response register set that figure.
// A stalled response holds its register; the request stage then fills and
// req_stall rises until the response is taken.
// Reset (arst_n low) empties the table at once: all valid bits and the count clear,
// no clearing pass is needed. Insert into a full table is refused and flagged.
// Depends on sat_pkg and sat_cell.
module sorted_array_table
	import sat_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  op_t  operation,
	input  key_t key,
	input  pos_t rank,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic hit,
	output key_t found_key,
	output pos_t position,
	output cnt_t entry_count,
	output logic refused
);

	// Request stage
	logic req_valid_s1;
	op_t  op_s1;
	key_t key_s1;
	pos_t rank_s1;

	// Response register
	logic rsp_valid_q;
	logic hit_q;
	key_t found_key_q;
	pos_t position_q;
	cnt_t entry_count_q;
	logic refused_q;

	cnt_t count_q;

	key_t             cell_key [DEPTH];
	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH-1:0] cell_flag;
	logic [DEPTH-1:0] cell_match;
	logic [DEPTH-1:0] bound_oh;

	sat_cmd_t cmd;
	logic     exec;
	logic     full;
	logic     bound_hit;
	pos_t     bound_pos;
	logic     sel_hit;
	logic     res_hit;
	key_t     res_key;
	pos_t     res_pos;
	cnt_t     res_count;
	logic     res_refused;

	// Execute when a request waits and the response register is free
	assign exec      = req_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = req_valid_s1 && !exec;
	assign full      = (count_q == CNT_W'(DEPTH));

	// Capture the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			op_s1   <= operation;
			key_s1  <= key;
			rank_s1 <= rank;
		end
	end

	// Build the chain of cells
	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			key_t lk;
			logic lf;
			logic lv;
			key_t rk;
			logic rv;
			if (i == 0) begin : g_first
				assign lk = '0;
				assign lf = 1'b1;
				assign lv = 1'b1;
			end else begin : g_mid_l
				assign lk = cell_key[i-1];
				assign lf = cell_flag[i-1];
				assign lv = cell_valid[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign rk = '0;
				assign rv = 1'b0;
			end else begin : g_mid_r
				assign rk = cell_key[i+1];
				assign rv = cell_valid[i+1];
			end
			assign bound_oh[i] = lf & ~cell_flag[i];

			sat_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.left_key   (lk),
				.left_flag  (lf),
				.left_valid (lv),
				.right_key  (rk),
				.right_valid(rv),
				.key_q      (cell_key[i]),
				.valid_q    (cell_valid[i]),
				.flag       (cell_flag[i]),
				.match      (cell_match[i])
			);
		end
	endgenerate

	// Encode the boundary between flagged and unflagged cells
	always_comb begin
		bound_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (bound_oh[i]) begin
				bound_pos = bound_pos | pos_t'(i);
			end
		end
		bound_hit = |(bound_oh & cell_match);
	end

	// Drive the broadcast command
	always_comb begin
		cmd.op         = op_s1;
		cmd.key        = key_s1;
		cmd.shift_up   = exec && (op_s1 == OP_INSERT) && !full;
		cmd.shift_down = exec && (op_s1 == OP_REMOVE) && bound_hit;
	end

	assign sel_hit = ({1'b0, rank_s1} < count_q);

	// Form the response
	always_comb begin
		res_hit     = 1'b0;
		res_key     = '0;
		res_pos     = '0;
		res_count   = count_q;
		res_refused = 1'b0;
		case (op_s1)
			OP_INSERT: begin
				if (full) begin
					res_refused = 1'b1;
				end else begin
					res_pos   = bound_pos;
					res_count = count_q + cnt_t'(1);
				end
			end
			OP_SEARCH: begin
				if (bound_hit) begin
					res_hit = 1'b1;
					res_key = key_s1;
					res_pos = bound_pos;
				end
			end
			OP_REMOVE: begin
				if (bound_hit) begin
					res_hit   = 1'b1;
					res_pos   = bound_pos;
					res_count = count_q - cnt_t'(1);
				end
			end
			OP_SELECT: begin
				if (sel_hit) begin
					res_hit = 1'b1;
					res_key = cell_key[rank_s1];
					res_pos = rank_s1;
				end
			end
			default: begin
				res_hit = 1'b0;
			end
		endcase
	end

	// Advance the count and the response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				count_q     <= res_count;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the response payload until it is taken
	always_ff @(posedge clk) begin
		if (exec) begin
			hit_q         <= res_hit;
			found_key_q   <= res_key;
			position_q    <= res_pos;
			entry_count_q <= res_count;
			refused_q     <= res_refused;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign found_key   = found_key_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;
	assign refused     = refused_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("entry count disagrees with cell valid bits");

	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && refused_q |-> entry_count_q == CNT_W'(DEPTH))
		else $error("insert refused while table not full");

	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (op_s1 == OP_INSERT) && !full |=> count_q == $past(count_q) + cnt_t'(1))
		else $error("insert did not grow the table");

	a_no_refused_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(refused_q && hit_q))
		else $error("response both refused and hit");
`endif

endmodule

// ----- sim/sorted_array_table_tb.sv -----
// Self-checking testbench for the sorted array table: directed, full-store,
// backpressure and random operation sequences checked against an in-bench table model.
// Depends on sat_pkg and the sorted_array_table RTL.
module sorted_array_table_tb;
	import sat_pkg::*;

	localparam int   HOLD_CYCLES    = 60;
	localparam int   WATCHDOG_LIMIT = 1000;
	localparam int   RANDOM_PHASES  = 8;
	localparam int   PHASE_ITEMS    = 130;
	localparam key_t KEY_MIN        = {1'b1, {(KEY_WIDTH-1){1'b0}}};
	localparam key_t KEY_MAX        = {1'b0, {(KEY_WIDTH-1){1'b1}}};

	typedef struct packed {
		logic hit;
		key_t found_key;
		pos_t position;
		cnt_t entry_count;
		logic refused;
	} table_rsp_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	op_t  operation = OP_INSERT;
	key_t key       = '0;
	pos_t rank      = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic hit;
	key_t found_key;
	pos_t position;
	cnt_t entry_count;
	logic refused;

	// Table model state
	key_t model_keys[DEPTH];
	int   model_count = 0;
	table_rsp_t pending_rsp[$];

	// Bench control; the hold, wait and idle state is written with nonblocking assignments at the rising edge
	bit   no_idle     = 1'b0;
	int   hold_seq    = 0;
	int   hold_seen   = 0;
	int   hold_left   = 0;
	int   rsp_wait    = 0;
	bit   req_fire    = 1'b0;
	bit   rsp_taken   = 1'b0;
	int   idle_cycles = 0;
	int   err_count   = 0;
	int   rsp_index   = 0;
	key_t key_pool[16];

	sorted_array_table u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.key        (key),
		.rank       (rank),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.hit        (hit),
		.found_key  (found_key),
		.position   (position),
		.entry_count(entry_count),
		.refused    (refused)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Wait in cycles before the next transaction on either side
	function automatic int draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	// Index of the first stored key that is not below k
	function automatic int first_not_below(key_t k);
		int i;
		i = 0;
		while (i < model_count && model_keys[i] < k)
			i++;
		return i;
	endfunction

	// Apply one operation to the table model and return its response
	function automatic table_rsp_t table_apply(op_t op, key_t k, pos_t r);
		table_rsp_t res;
		int i;
		int j;
		res = '0;
		case (op)
			OP_INSERT: begin
				if (model_count >= DEPTH) begin
					res.refused = 1'b1;
				end else begin
					i = model_count;
					while (i > 0 && k < model_keys[i-1]) begin
						model_keys[i] = model_keys[i-1];
						i--;
					end
					model_keys[i] = k;
					model_count++;
					res.position = pos_t'(i);
				end
			end
			OP_SEARCH: begin
				i = first_not_below(k);
				if (i < model_count && model_keys[i] == k) begin
					res.hit       = 1'b1;
					res.found_key = k;
					res.position  = pos_t'(i);
				end
			end
			OP_REMOVE: begin
				i = first_not_below(k);
				if (i < model_count && model_keys[i] == k) begin
					res.hit      = 1'b1;
					res.position = pos_t'(i);
					for (j = i; j + 1 < model_count; j++)
						model_keys[j] = model_keys[j+1];
					model_count--;
				end
			end
			default: begin
				if (int'(r) < model_count) begin
					res.hit       = 1'b1;
					res.found_key = model_keys[r];
					res.position  = r;
				end
			end
		endcase
		res.entry_count = cnt_t'(model_count);
		return res;
	endfunction

	// Print one mismatch line and count it
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at response %0d: %s got %h want %h", rsp_index, what, got, want);
		err_count++;
	endtask

	// Offer one request transaction; return at the edge that accepts it, valid still high
	task automatic send_op(input op_t op, input key_t k, input pos_t r);
		int  gap;
		bit  taken;
		gap = draw_wait();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		key       <= k;
		rank      <= r;
		do begin
			@(negedge clk);
			taken = !req_stall;
			if (taken)
				pending_rsp.push_back(table_apply(op, k, r));
			@(posedge clk);
		end while (!taken);
	endtask

	// Key choice: stored keys, a small pool with the extremes, or any value
	function automatic key_t pick_key(bit prefer_stored);
		int sel;
		sel = $urandom_range(0, 9);
		if (prefer_stored && model_count > 0 && sel < 5)
			return model_keys[$urandom_range(0, model_count - 1)];
		if (sel < 8)
			return key_pool[$urandom_range(0, 15)];
		return key_t'($urandom);
	endfunction

	function automatic pos_t pick_rank();
		if ($urandom_range(0, 4) != 0)
			return pos_t'($urandom_range(0, (model_count < DEPTH - 1) ? model_count : DEPTH - 1));
		return pos_t'($urandom);
	endfunction

	// Empty store, extremes, duplicates, misses and out-of-range select
	task automatic test_directed();
		send_op(OP_SELECT, '0, pos_t'(0));
		send_op(OP_SELECT, '0, pos_t'(DEPTH - 1));
		send_op(OP_SEARCH, '0, '0);
		send_op(OP_REMOVE, '0, '0);
		send_op(OP_INSERT, KEY_MIN, '0);
		send_op(OP_INSERT, KEY_MAX, '0);
		send_op(OP_INSERT, '0, '0);
		send_op(OP_INSERT, -1, '0);
		repeat (3) send_op(OP_INSERT, 5, '0);
		send_op(OP_SEARCH, 5, '0);
		send_op(OP_SEARCH, KEY_MIN, '0);
		send_op(OP_SEARCH, KEY_MAX, '0);
		send_op(OP_SEARCH, 4, '0);
		send_op(OP_REMOVE, 5, '0);
		send_op(OP_SELECT, '0, pos_t'(0));
		send_op(OP_SELECT, '0, pos_t'(model_count - 1));
		send_op(OP_SELECT, '0, pos_t'(model_count));
		send_op(OP_REMOVE, KEY_MAX, '0);
		send_op(OP_REMOVE, KEY_MIN, '0);
		send_op(OP_REMOVE, 7, '0);
		send_op(OP_SEARCH, -1, '0);
	endtask

	// Fill the store, insert into it while full, then drain it
	task automatic test_full_store();
		while (model_count < DEPTH)
			send_op(OP_INSERT, pick_key(1'b0), pick_rank());
		send_op(OP_INSERT, KEY_MAX, '0);
		send_op(OP_INSERT, KEY_MIN, '0);
		send_op(OP_SELECT, '0, pos_t'(DEPTH - 1));
		send_op(OP_SELECT, '0, pos_t'(0));
		send_op(OP_SEARCH, pick_key(1'b1), '0);
		send_op(OP_REMOVE, model_keys[DEPTH - 1], '0);
		send_op(OP_INSERT, pick_key(1'b0), '0);
		send_op(OP_INSERT, pick_key(1'b0), '0);
		while (model_count > 0)
			send_op(OP_REMOVE, model_keys[$urandom_range(0, model_count - 1)], '0);
		send_op(OP_SEARCH, pick_key(1'b0), '0);
	endtask

	// Hold the response side while requests keep coming, so the input stalls
	task automatic test_backpressure();
		hold_seq <= hold_seq + 1;
		no_idle  <= 1'b1;
		repeat (30)
			send_op(op_t'($urandom_range(0, 3)), pick_key(1'b1), pick_rank());
	endtask

	// Alternate growing and shrinking phases so the store swings between empty and full
	task automatic test_random();
		int   p;
		int   n;
		int   sel;
		op_t  op;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			no_idle <= ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (p % 2 == 0)
					op = (sel < 55) ? OP_INSERT : (sel < 70) ? OP_REMOVE :
						(sel < 85) ? OP_SEARCH : OP_SELECT;
				else
					op = (sel < 15) ? OP_INSERT : (sel < 60) ? OP_REMOVE :
						(sel < 80) ? OP_SEARCH : OP_SELECT;
				send_op(op, pick_key(op != OP_INSERT), pick_rank());
			end
		end
		no_idle <= 1'b0;
	endtask

	// Check each response transaction against the oldest expectation
	always @(negedge clk) begin : rsp_check
		table_rsp_t got;
		table_rsp_t want;
		req_fire  = arst_n && req_valid && !req_stall;
		rsp_taken = arst_n && rsp_valid && !rsp_stall;
		if (rsp_taken) begin
			got.hit         = hit;
			got.found_key   = found_key;
			got.position    = position;
			got.entry_count = entry_count;
			got.refused     = refused;
			if (pending_rsp.size() == 0) begin
				report_mismatch("response with nothing expected", 64'(got), '0);
			end else begin
				want = pending_rsp.pop_front();
				if (got.hit !== want.hit)
					report_mismatch("hit", 64'(got.hit), 64'(want.hit));
				if (got.found_key !== want.found_key)
					report_mismatch("found_key", 64'(got.found_key), 64'(want.found_key));
				if (got.position !== want.position)
					report_mismatch("position", 64'(got.position), 64'(want.position));
				if (got.entry_count !== want.entry_count)
					report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
				if (got.refused !== want.refused)
					report_mismatch("refused", 64'(got.refused), 64'(want.refused));
			end
			rsp_index++;
		end
	end

	// Drive response stall: long hold on request, else a random wait after each transaction
	always @(posedge clk) begin : rsp_stall_drive
		int gap;
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES - 1;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (rsp_wait != 0) begin
			rsp_wait  <= rsp_wait - 1;
			rsp_stall <= 1'b1;
		end else if (rsp_taken) begin
			gap = draw_wait();
			rsp_wait  <= (gap == 0) ? 0 : gap - 1;
			rsp_stall <= (gap != 0);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || req_fire || rsp_taken) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = '0;
		key_pool[3] = -1;
		for (int i = 4; i < 16; i++)
			key_pool[i] = key_t'($urandom);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_store();
		test_backpressure();
		test_random();
		req_valid <= 1'b0;

		// Drain outstanding responses, then let the clock run on before reporting
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
